[rtl/cafu_pkg.sv]
// ----------------------------------------------------------------------------
// cafu_pkg
// shared types and constants of the cell association flow table unit
// ----------------------------------------------------------------------------
package cafu_pkg;

    localparam int KEY_W   = 48;
    localparam int CELL_W  = 16;
    localparam int ENTRY_W = 1 + KEY_W + CELL_W;   // {valid, key, cell}

    localparam logic [15:0] ETH_IPV4       = 16'h0800;
    localparam logic [3:0]  IP_VER4        = 4'd4;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [31:0] PREAMBLE_RESET = 32'hD066_F00D;
    localparam logic [7:0]  UPD_EXTERIOR   = 8'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_IPV4  = 3'd1;
    localparam logic [2:0] ST_BAD_VER   = 3'd2;
    localparam logic [2:0] ST_NOT_UDP   = 3'd3;
    localparam logic [2:0] ST_BAD_PRE   = 3'd4;
    localparam logic [2:0] ST_NO_ASSOC  = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    typedef struct packed {
        logic        direction;
        logic [15:0] eth_type;
        logic [3:0]  ip_version;
        logic [7:0]  ip_proto;
        logic [31:0] src_ip;
        logic [15:0] src_udp;
        logic [31:0] dst_ip;
        logic [15:0] dst_udp;
        logic [31:0] preamble;
        logic [15:0] cell_id;
        logic [7:0]  update_flag;
    } cafu_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_cell_id;
        logic [7:0]  out_update;
        logic        announced;
    } cafu_rsp_t;

endpackage

[rtl/cell_association_flow_table_unit.sv]
// ----------------------------------------------------------------------------
// cell_association_flow_table_unit
// exact-match flow table from client address and port to cell id
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          contents
//  s_*       in         s_valid / s_ready  parsed packet header fields
//  m_*       out        m_valid / m_ready  status, cell id, update byte, announce
//  cfg_*     in         cfg_we             expected preamble word
//
//  a request is accepted only once the last result has left the engine; one
//  that fails a header check passes the hash and finish states, one that
//  reaches the table also probes, decides and, when ENTRIES is not a power of two,
//  reduces the index first, with one read of the single table ram per probed slot.
//  after reset the table ram is swept to empty, one slot per cycle, over all
//  ENTRIES slots; s_ready stays low meanwhile, cfg writes are taken.
//  a stalled result sits in the output register while the next request
//  is accepted and processed.
//
module cell_association_flow_table_unit
    import cafu_pkg::*;
#(
    parameter int ENTRIES     = 4096,
    parameter int PROBE_LIMIT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,

    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_direction,
    input  logic [15:0] s_eth_type,
    input  logic [3:0]  s_ip_version,
    input  logic [7:0]  s_ip_proto,
    input  logic [31:0] s_src_ip,
    input  logic [15:0] s_src_udp,
    input  logic [31:0] s_dst_ip,
    input  logic [15:0] s_dst_udp,
    input  logic [31:0] s_preamble,
    input  logic [15:0] s_cell_id,
    input  logic [7:0]  s_update_flag,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_out_cell_id,
    output logic [7:0]  m_out_update,
    output logic        m_announced
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [31:0] preamble_reg;

    // result output register
    logic        m_valid_reg, m_valid_next;
    cafu_rsp_t   out_reg, out_next;

    cafu_req_t   req;
    cafu_rsp_t   rsp;
    logic        rsp_valid;
    logic        rsp_ready;

    // table ram port: {valid, key, cell} per slot
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    assign req = '{
        direction:   s_direction,
        eth_type:    s_eth_type,
        ip_version:  s_ip_version,
        ip_proto:    s_ip_proto,
        src_ip:      s_src_ip,
        src_udp:     s_src_udp,
        dst_ip:      s_dst_ip,
        dst_udp:     s_dst_udp,
        preamble:    s_preamble,
        cell_id:     s_cell_id,
        update_flag: s_update_flag
    };

    // expected preamble register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_reg <= PREAMBLE_RESET;
        end else if (cfg_we) begin
            preamble_reg <= cfg_wdata;
        end
    end

    cafu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cafu_engine #(
        .ENTRIES     (ENTRIES),
        .PROBE_LIMIT (PROBE_LIMIT)
    ) u_engine (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .expected_preamble (preamble_reg),
        .req_valid         (s_valid),
        .req_ready         (s_ready),
        .req               (req),
        .rsp_valid         (rsp_valid),
        .rsp_ready         (rsp_ready),
        .rsp               (rsp),
        .ram_we            (ram_we),
        .ram_waddr         (ram_waddr),
        .ram_wdata         (ram_wdata),
        .ram_raddr         (ram_raddr),
        .ram_rdata         (ram_rdata)
    );

    // engine hands over when the output register is empty or draining
    assign rsp_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (rsp_valid && rsp_ready) begin
            m_valid_next = 1'b1;
            out_next     = rsp;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_reg.status;
    assign m_out_cell_id = out_reg.out_cell_id;
    assign m_out_update  = out_reg.out_update;
    assign m_announced   = out_reg.announced;

endmodule

[rtl/cafu_ram.sv]
// ----------------------------------------------------------------------------
// cafu_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cafu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/cafu_engine.sv]
// ----------------------------------------------------------------------------
// cafu_engine
// header check, slot index, probe sequencer and table update
// ----------------------------------------------------------------------------
module cafu_engine
    import cafu_pkg::*;
#(
    parameter int ENTRIES     = 4096,
    parameter int PROBE_LIMIT = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [31:0]                expected_preamble,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  cafu_req_t                  req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output cafu_rsp_t                  rsp,
    output logic                       ram_we,
    output logic [$clog2(ENTRIES)-1:0] ram_waddr,
    output logic [ENTRY_W-1:0]         ram_wdata,
    output logic [$clog2(ENTRIES)-1:0] ram_raddr,
    input  logic [ENTRY_W-1:0]         ram_rdata
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(PROBE_LIMIT + 1);
    localparam bit IS_POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);
    localparam logic [16:0] ENT17 = 17'(ENTRIES);
    // reciprocal of ENTRIES, exact quotient for every 16-bit fold
    localparam longint RECIP_L = ((longint'(1) << (16 + IDX_W)) + longint'(ENTRIES) - 1)
                                 / longint'(ENTRIES);
    localparam logic [16:0] RECIP = 17'(RECIP_L);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] PROBES = CNT_W'(PROBE_LIMIT);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HASH   = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_PROBE  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;
    localparam logic [2:0] S_CLEAR  = 3'd6;
    localparam logic [2:0] S_MOD    = 3'd7;

    // control
    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0] iss_cnt_reg, iss_cnt_next;
    logic             pend_reg, pend_next;
    logic             hit_reg, hit_next;
    logic             emp_reg, emp_next;

    // payload
    logic [IDX_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]  emp_idx_reg, emp_idx_next;
    logic [CELL_W-1:0] hit_cell_reg, hit_cell_next;
    logic [15:0]       rem_reg, rem_next;
    logic [16:0]       quo_reg, quo_next;
    logic              dir_reg, dir_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [15:0]       cell_reg, cell_next;
    logic [7:0]        upd_reg, upd_next;
    cafu_rsp_t         rsp_reg, rsp_next;

    logic [2:0]       chk_status;
    logic [15:0]      fold;
    logic [IDX_W-1:0] addr_inc;
    logic [32:0]      prod;
    logic [15:0]      back;
    logic [15:0]      red_rem;
    logic             rd_valid;
    logic [KEY_W-1:0] rd_key;
    logic             store;

    always_comb begin
        if (req.eth_type != ETH_IPV4) begin
            chk_status = ST_NOT_IPV4;
        end else if (req.ip_version != IP_VER4) begin
            chk_status = ST_BAD_VER;
        end else if (req.ip_proto != PROTO_UDP) begin
            chk_status = ST_NOT_UDP;
        end else if (req.preamble != expected_preamble) begin
            chk_status = ST_BAD_PRE;
        end else begin
            chk_status = ST_OK;
        end
    end

    assign fold     = key_reg[47:32] ^ key_reg[31:16] ^ key_reg[15:0];
    assign addr_inc = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
    assign prod     = {17'd0, rem_reg} * {16'd0, RECIP};
    assign back     = 16'(quo_reg * ENT17);
    assign red_rem  = rem_reg - back;
    assign rd_valid = ram_rdata[ENTRY_W-1];
    assign rd_key   = ram_rdata[ENTRY_W-2:CELL_W];
    assign store    = !hit_reg || (upd_reg != 8'd0);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_FINISH);
    assign rsp       = rsp_reg;
    assign ram_raddr = addr_reg;

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        iss_cnt_next   = iss_cnt_reg;
        pend_next      = 1'b0;
        hit_next       = hit_reg;
        emp_next       = emp_reg;
        pend_addr_next = addr_reg;
        hit_idx_next   = hit_idx_reg;
        emp_idx_next   = emp_idx_reg;
        hit_cell_next  = hit_cell_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dir_next       = dir_reg;
        key_next       = key_reg;
        cell_next      = cell_reg;
        upd_next       = upd_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = '0;

        case (state_reg)
            S_CLEAR: begin
                ram_we = 1'b1;
                addr_next = addr_inc;
                if (addr_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_valid) begin
                    dir_next  = req.direction;
                    key_next  = req.direction ? {req.dst_ip, req.dst_udp}
                                              : {req.src_ip, req.src_udp};
                    cell_next = req.cell_id;
                    upd_next  = req.update_flag;
                    rsp_next  = '{status: chk_status, out_cell_id: req.cell_id,
                                  out_update: req.update_flag, announced: 1'b0};
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                hit_next = 1'b0;
                emp_next = 1'b0;
                iss_cnt_next = '0;
                if (rsp_reg.status != ST_OK) begin
                    state_next = S_FINISH;
                end else if (IS_POW2) begin
                    addr_next  = fold[IDX_W-1:0];
                    state_next = S_PROBE;
                end else begin
                    rem_next   = fold;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE: begin
                // quotient by reciprocal multiply
                quo_next   = 17'(prod >> (16 + IDX_W));
                state_next = S_MOD;
            end
            S_MOD: begin
                addr_next  = red_rem[IDX_W-1:0];
                state_next = S_PROBE;
            end
            S_PROBE: begin
                if (iss_cnt_reg != PROBES) begin
                    pend_next    = 1'b1;
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                    addr_next    = addr_inc;
                end else begin
                    state_next = S_DECIDE;
                end
                if (pend_reg) begin
                    if (rd_valid) begin
                        if (!hit_reg && rd_key == key_reg) begin
                            hit_next      = 1'b1;
                            hit_idx_next  = pend_addr_reg;
                            hit_cell_next = ram_rdata[CELL_W-1:0];
                        end
                    end else if (!emp_reg) begin
                        emp_next     = 1'b1;
                        emp_idx_next = pend_addr_reg;
                    end
                end
            end
            S_DECIDE: begin
                state_next = S_FINISH;
                if (!dir_reg) begin
                    rsp_next.out_cell_id = '0;
                    if (store) begin
                        if (hit_reg || emp_reg) begin
                            ram_we    = 1'b1;
                            ram_waddr = hit_reg ? hit_idx_reg : emp_idx_reg;
                            ram_wdata = {1'b1, key_reg, cell_reg};
                            rsp_next.announced = 1'b1;
                        end else begin
                            rsp_next.status = ST_FULL;
                        end
                    end
                end else if (hit_reg) begin
                    rsp_next.out_cell_id = hit_cell_reg;
                    rsp_next.out_update  = UPD_EXTERIOR;
                end else begin
                    rsp_next.status = ST_NO_ASSOC;
                end
            end
            S_FINISH: begin
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            addr_reg    <= '0;
            iss_cnt_reg <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            emp_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            iss_cnt_reg <= iss_cnt_next;
            pend_reg    <= pend_next;
            hit_reg     <= hit_next;
            emp_reg     <= emp_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= pend_addr_next;
        hit_idx_reg   <= hit_idx_next;
        emp_idx_reg   <= emp_idx_next;
        hit_cell_reg  <= hit_cell_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dir_reg       <= dir_next;
        key_reg       <= key_next;
        cell_reg      <= cell_next;
        upd_reg       <= upd_next;
        rsp_reg       <= rsp_next;
    end

endmodule
